// ===== design/triangle_face_dedup_top_assert.svh =====
// Assertion macros for the triangle face dedup block.
// Included by the top level; needs clock and reset in scope.
`ifndef TRIANGLE_FACE_DEDUP_TOP_ASSERT_SVH
`define TRIANGLE_FACE_DEDUP_TOP_ASSERT_SVH
// Implication checked at every clock edge outside reset
`define TFD_ASSERT_IMPL(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication
`define TFD_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ===== design/tfd_pkg.sv =====
// Shared types and constants for the triangle face dedup block.
// No dependencies.
package tfd_pkg;
   localparam int unsigned CfgBits = 1;
endpackage

// ===== design/tfd_if.sv =====
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface tfd_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/tfd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
module tfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   // write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/triangle_face_dedup_top.sv =====
// Top level of the triangle face dedup block: key build, probe sequencer, table RAM.
// Depends on tfd_pkg, tfd_ram and the assertion macro header.
//
// channel | dir | payload
// req     | in  | start_mesh, face_index, vertex_a/b/c
// rsp     | out | is_duplicate, root_face, table_full
// csr     | in  | ignore_orientation (1 bit)
//
// After reset the table is swept clear before req is taken.
// A start_mesh beat sweeps the table clear first.
// Otherwise the request goes through key build, then a read and a compare per probe
// (the single RAM read port serves one probe at a time); a first-slot hit or miss
// needs one probe. The result sits in an output register; the next request beat can
// be taken in the cycle after it has left, so one request is handled at a time.
`include "triangle_face_dedup_top_assert.svh"
module triangle_face_dedup_top #(
   parameter int VERTEX_BITS   = 20,
   parameter int FACE_BITS     = 20,
   parameter int TABLE_ENTRIES = 4096,
   parameter int PROBE_LIMIT   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_start_mesh,
   input  logic [FACE_BITS-1:0]   req_face_index,
   input  logic [VERTEX_BITS-1:0] req_vertex_a,
   input  logic [VERTEX_BITS-1:0] req_vertex_b,
   input  logic [VERTEX_BITS-1:0] req_vertex_c,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_duplicate,
   output logic [FACE_BITS-1:0]   rsp_root_face,
   output logic                   rsp_table_full,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [tfd_pkg::CfgBits-1:0] csr_ignore_orientation
);
   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int KW = 3 * VERTEX_BITS;
   localparam int EW = KW + FACE_BITS + 1;   // valid, key, root
   localparam int PW = $clog2(PROBE_LIMIT + 1);

   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_KEY, S_READ, S_CMP, S_OUT} state_type;

   state_type               state_ff;
   logic [AW-1:0]           addr_ff;
   logic [PW-1:0]           probe_ff;
   logic                    mode_ff;
   logic                    start_ff;
   logic [FACE_BITS-1:0]    face_ff;
   logic [VERTEX_BITS-1:0]  va_ff, vb_ff, vc_ff;
   logic [KW-1:0]           key_ff;
   logic                    dup_ff, full_ff;
   logic [FACE_BITS-1:0]    root_ff;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [EW-1:0]           wr_data, rd_data;
   logic [KW-1:0]           key_in;

   // canonical key: sorted or smallest rotation
   function automatic logic lex_lt(input logic [KW-1:0] x, input logic [KW-1:0] y);
      lex_lt = x < y;   // packed {v0,v1,v2} compares lexicographically
   endfunction

   always_comb begin
      logic [VERTEX_BITS-1:0] k0, k1, k2, t;
      logic [KW-1:0] r0, r1, r2;
      t = '0;
      k0 = va_ff; k1 = vb_ff; k2 = vc_ff;
      if (k0 > k1) begin t = k0; k0 = k1; k1 = t; end
      if (k1 > k2) begin t = k1; k1 = k2; k2 = t; end
      if (k0 > k1) begin t = k0; k0 = k1; k1 = t; end
      r0 = {va_ff, vb_ff, vc_ff};
      r1 = {vb_ff, vc_ff, va_ff};
      r2 = {vc_ff, va_ff, vb_ff};
      if (lex_lt(r1, r0)) r0 = r1;
      if (lex_lt(r2, r0)) r0 = r2;
      key_in = mode_ff ? {k0, k1, k2} : r0;
   end

   // one RAM holds valid, key and root for each slot
   tfd_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   logic          ent_valid;
   logic [KW-1:0] ent_key;
   assign ent_valid = rd_data[EW-1];
   assign ent_key   = rd_data[EW-2 -: KW];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = {1'b1, key_ff, face_ff};
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_data = '0;
      end else if (state_ff == S_CMP && !ent_valid) begin
         wr_en = 1'b1;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_is_duplicate = dup_ff;
   assign rsp_root_face    = root_ff;
   assign rsp_table_full   = full_ff;

   // sequencer: clear sweep, key build, probe read/compare, hold result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         mode_ff  <= 1'b0;
         start_ff <= 1'b0;
         probe_ff <= '0;
      end else begin
         if (csr_valid) mode_ff <= csr_ignore_orientation[0];
         unique case (state_ff)
            S_CLEAR: begin
               addr_ff <= addr_ff + 1'b1;
               if (addr_ff == AW'(TABLE_ENTRIES - 1))
                  state_ff <= start_ff ? S_KEY : S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  face_ff  <= req_face_index;
                  va_ff    <= req_vertex_a;
                  vb_ff    <= req_vertex_b;
                  vc_ff    <= req_vertex_c;
                  start_ff <= req_start_mesh;
                  addr_ff  <= '0;
                  state_ff <= req_start_mesh ? S_CLEAR : S_KEY;
               end
            end
            S_KEY: begin
               key_ff   <= key_in;
               addr_ff  <= AW'(key_in[KW-1 -: VERTEX_BITS]
                              ^ key_in[2*VERTEX_BITS-1 -: VERTEX_BITS]
                              ^ key_in[VERTEX_BITS-1:0]);
               probe_ff <= '0;
               start_ff <= 1'b0;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_CMP;
            S_CMP: begin
               if (!ent_valid) begin
                  dup_ff <= 1'b0; root_ff <= face_ff; full_ff <= 1'b0;
                  state_ff <= S_OUT;
               end else if (ent_key == key_ff) begin
                  dup_ff <= 1'b1; root_ff <= rd_data[FACE_BITS-1:0]; full_ff <= 1'b0;
                  state_ff <= S_OUT;
               end else if (probe_ff == PW'(PROBE_LIMIT - 1)) begin
                  dup_ff <= 1'b0; root_ff <= face_ff; full_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  probe_ff <= probe_ff + 1'b1;
                  addr_ff  <= addr_ff + 1'b1;
                  state_ff <= S_READ;
               end
            end
            S_OUT: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `TFD_ASSERT_IMPL(a_no_req_in_flight, req_ready, !rsp_valid)
   `TFD_ASSERT_IMPL(a_flags_exclusive, rsp_valid, !(rsp_is_duplicate && rsp_table_full))
   `TFD_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_root_face))
   `TFD_ASSERT_IMPL(a_probe_bound, state_ff == S_CMP, probe_ff < PW'(PROBE_LIMIT))
endmodule

// ===== test/tfd_face_checker.sv =====
// Checker for the triangle face dedup block: tracks the orientation mode and the face table.
// Predicts each response from accepted request beats and compares it field by field.
// Depends on tfd_pkg only.
module tfd_face_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [80:0]                 req_payload,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [21:0]                 rsp_payload,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [tfd_pkg::CfgBits-1:0] csr_ignore_orientation,
   output int                          fail_count,
   output int                          outstanding
);
   localparam int Slots = 4096;
   localparam int Probes = 8;

   typedef struct packed {
      logic        dup;
      logic [19:0] root;
      logic        full;
   } face_verdict_type;

   logic [59:0]      slot_key [Slots];
   logic [19:0]      slot_root [Slots];
   logic             slot_used [Slots];
   logic             any_order;
   face_verdict_type verdicts_due [$];

   // Canonical key: the lexicographically smallest rotation, or the sorted triple
   function automatic logic [59:0] face_key(input logic [19:0] a, input logic [19:0] b,
                                            input logic [19:0] c, input logic unordered);
      logic [59:0] k;
      logic [59:0] r;
      logic [19:0] t0;
      logic [19:0] t1;
      logic [19:0] t2;
      logic [19:0] sw;
      if (unordered) begin
         t0 = a; t1 = b; t2 = c;
         if (t0 > t1) begin sw = t0; t0 = t1; t1 = sw; end
         if (t1 > t2) begin sw = t1; t1 = t2; t2 = sw; end
         if (t0 > t1) begin sw = t0; t0 = t1; t1 = sw; end
         k = {t0, t1, t2};
      end else begin
         k = {a, b, c};
         r = {b, c, a};
         if (r < k) k = r;
         r = {c, a, b};
         if (r < k) k = r;
      end
      return k;
   endfunction

   // Clear the table on start_mesh, look the face up, store it on a miss, and return the expected response
   function automatic face_verdict_type look_up_face(input logic [80:0] beat);
      face_verdict_type v;
      logic [59:0]      k;
      int               s;
      if (beat[80]) foreach (slot_used[i]) slot_used[i] = 1'b0;
      k = face_key(beat[59:40], beat[39:20], beat[19:0], any_order);
      v.dup = 1'b0;
      v.root = beat[79:60];
      v.full = 1'b1;
      for (int p = 0; p < Probes; p++) begin
         s = ((k[59:40] ^ k[39:20] ^ k[19:0]) + p) % Slots;
         if (!slot_used[s]) begin
            slot_used[s] = 1'b1;
            slot_key[s] = k;
            slot_root[s] = beat[79:60];
            v.full = 1'b0;
            break;
         end
         if (slot_key[s] == k) begin
            v.dup = 1'b1;
            v.root = slot_root[s];
            v.full = 1'b0;
            break;
         end
      end
      return v;
   endfunction

   initial begin
      fail_count = 0;
      outstanding = 0;
      any_order = 1'b0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
   end

   always @(posedge clock) begin
      face_verdict_type want;
      face_verdict_type got;
      if (reset) begin
         any_order = 1'b0;
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         verdicts_due.delete();
      end else begin
         if (csr_valid && csr_ready) any_order = csr_ignore_orientation[0];
         // compare each response beat with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (verdicts_due.size() == 0) begin
               $display("%0t: response with none expected: dup %0b root %0d full %0b",
                        $time, got.dup, got.root, got.full);
               fail_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (got.dup != want.dup) begin
                  $display("%0t: is_duplicate expected %0b actual %0b",
                           $time, want.dup, got.dup);
                  fail_count++;
               end
               if (got.root != want.root) begin
                  $display("%0t: root_face expected %0d actual %0d",
                           $time, want.root, got.root);
                  fail_count++;
               end
               if (got.full != want.full) begin
                  $display("%0t: table_full expected %0b actual %0b",
                           $time, want.full, got.full);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            verdicts_due.insert(verdicts_due.size(), look_up_face(req_payload));
      end
      outstanding = verdicts_due.size();
   end
endmodule

// ===== test/triangle_face_dedup_top_tb.sv =====
// Stimulus and verdict for the triangle face dedup block.
// Depends on tfd_pkg, tfd_if, triangle_face_dedup_top and tfd_face_checker.
module triangle_face_dedup_top_tb;
   logic clock;
   logic reset;
   logic csr_valid;
   logic csr_ready;
   logic [tfd_pkg::CfgBits-1:0] csr_data;
   logic req_calm;
   logic rsp_calm;
   int   fail_count;
   int   outstanding;
   logic [19:0] mesh_faces [$];
   logic [19:0] next_face;

   tfd_if #(.PAYLOAD_TYPE(logic [80:0])) req_ch ();
   tfd_if #(.PAYLOAD_TYPE(logic [21:0])) rsp_ch ();

   triangle_face_dedup_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready),
      .req_start_mesh(req_ch.payload[80]), .req_face_index(req_ch.payload[79:60]),
      .req_vertex_a(req_ch.payload[59:40]), .req_vertex_b(req_ch.payload[39:20]),
      .req_vertex_c(req_ch.payload[19:0]),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
      .rsp_is_duplicate(rsp_ch.payload[21]), .rsp_root_face(rsp_ch.payload[20:1]),
      .rsp_table_full(rsp_ch.payload[0]),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_ignore_orientation(csr_data)
   );

   tfd_face_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_payload(req_ch.payload),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_payload(rsp_ch.payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_ignore_orientation(csr_data),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hold one face beat until accepted; valid stays high for the next beat unless a random gap drops it
   task automatic send_face(input logic start, input logic [19:0] face,
                            input logic [19:0] a, input logic [19:0] b, input logic [19:0] c);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= {start, face, a, b, c};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Drop valid and wait for every response to drain
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_mode(input logic mode);
      csr_valid <= 1'b1;
      csr_data <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random face, sometimes opening a new mesh: a reordered repeat, a clustered new face, a degenerate one or noise
   task automatic random_face();
      logic        start;
      logic [19:0] v [3];
      logic [19:0] sw;
      int          pick;
      int          j;
      start = ($urandom_range(0, 39) == 0);
      if (start) mesh_faces.delete();
      pick = $urandom_range(0, 99);
      if (pick < 35 && mesh_faces.size() >= 3) begin
         j = $urandom_range(0, mesh_faces.size() / 3 - 1) * 3;
         v[0] = mesh_faces[j]; v[1] = mesh_faces[j+1]; v[2] = mesh_faces[j+2];
         repeat ($urandom_range(0, 2)) begin
            sw = v[0]; v[0] = v[1]; v[1] = v[2]; v[2] = sw;
         end
         if ($urandom_range(0, 1)) begin sw = v[0]; v[0] = v[1]; v[1] = sw; end
      end else if (pick < 75) begin
         foreach (v[i]) v[i] = 20'($urandom_range(0, 31));
      end else if (pick < 83) begin
         v[0] = 20'($urandom);
         v[1] = $urandom_range(0, 1) ? v[0] : 20'($urandom);
         v[2] = v[0];
      end else begin
         foreach (v[i]) v[i] = 20'($urandom);
      end
      foreach (v[i]) mesh_faces.insert(mesh_faces.size(), v[i]);
      next_face = $urandom_range(0, 3) == 0 ? 20'($urandom) : next_face + 20'd1;
      send_face(start, next_face, v[0], v[1], v[2]);
   endtask

   // Response side: random stalls per beat, with calm stretches
   initial begin
      rsp_ch.ready <= 1'b0;
      @(negedge reset);
      forever begin
         int stall;
         stall = rsp_calm ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   initial begin
      #40000000;
      $display("triangle_face_dedup_top_tb: errors");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      req_calm = 1'b0;
      rsp_calm = 1'b0;
      next_face = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mode(1'b0);

      // Extremes, rotations and degenerate faces in oriented mode
      send_face(1'b1, 20'd0, 20'd0, 20'd0, 20'd0);
      send_face(1'b0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      send_face(1'b0, 20'd5, 20'd7, 20'd3, 20'd9);
      send_face(1'b0, 20'd6, 20'd3, 20'd9, 20'd7);
      send_face(1'b0, 20'd7, 20'd9, 20'd7, 20'd3);
      send_face(1'b0, 20'd8, 20'd3, 20'd7, 20'd9);
      send_face(1'b0, 20'd9, 20'd4, 20'd4, 20'd8);
      send_face(1'b0, 20'd10, 20'd8, 20'd4, 20'd4);
      // Ten keys hashing to slot zero, after face 0 took it: the eighth and later run out of probes
      send_face(1'b0, 20'd11, 20'd1, 20'd2, 20'd3);
      send_face(1'b0, 20'd12, 20'd1, 20'd4, 20'd5);
      send_face(1'b0, 20'd13, 20'd1, 20'd6, 20'd7);
      send_face(1'b0, 20'd14, 20'd2, 20'd4, 20'd6);
      send_face(1'b0, 20'd15, 20'd2, 20'd5, 20'd7);
      send_face(1'b0, 20'd16, 20'd3, 20'd4, 20'd7);
      send_face(1'b0, 20'd17, 20'd3, 20'd5, 20'd6);
      send_face(1'b0, 20'd18, 20'd1, 20'd8, 20'd9);
      send_face(1'b0, 20'd19, 20'd1, 20'd10, 20'd11);
      send_face(1'b0, 20'd20, 20'd3, 20'd2, 20'd1);
      // Probe wraps past the last slot
      send_face(1'b0, 20'd21, 20'd4095, 20'd0, 20'd0);
      send_face(1'b0, 20'd22, 20'd4094, 20'd1, 20'd0);
      drain();

      // Any order: keys stored oriented stay oriented
      write_mode(1'b1);
      send_face(1'b0, 20'd23, 20'd9, 20'd3, 20'd7);
      send_face(1'b0, 20'd24, 20'd7, 20'd9, 20'd3);
      send_face(1'b0, 20'd25, 20'd0, 20'd0, 20'd0);
      send_face(1'b1, 20'd26, 20'd9, 20'd7, 20'd3);
      drain();

      // Random phases through both modes, without clearing on a mode change
      for (int ph = 0; ph < 4; ph++) begin
         if (ph > 0) write_mode(ph == 1 || ph == 2 ? 1'b0 : 1'b1);
         for (int n = 0; n < 110; n++) begin
            if (n % 25 == 0) begin
               req_calm = ($urandom_range(0, 3) == 0);
               rsp_calm = ($urandom_range(0, 3) == 0);
            end
            random_face();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("triangle_face_dedup_top_tb: clean");
      end else begin
         $display("triangle_face_dedup_top_tb: errors");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+design
design/tfd_pkg.sv
design/tfd_if.sv
design/tfd_ram.sv
design/triangle_face_dedup_top.sv
test/tfd_face_checker.sv
test/triangle_face_dedup_top_tb.sv
